// ===== rtl/core/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and glyph lookup for the meter display scan driver.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int NUM_DIGITS  = 3;

	localparam logic [13:0] MAX_READING = 14'd9999;
	localparam logic [13:0] SPLIT_LIMIT = 14'd1000;

	// reciprocal constants for exact divide-by-constant on bounded inputs
	localparam logic [12:0] RECIP10_V  = 13'd6554;  // v/10   = v*6554 >> 16, v < 16384
	localparam logic [7:0]  RECIP10_Q  = 8'd205;    // q/10   = q*205  >> 11, q < 1024
	localparam logic [5:0]  RECIP100_Q = 6'd41;     // q/100  = q*41   >> 12, q < 1024

	localparam logic [4:0] DP_OFFSET = 5'd10;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef logic [4:0] code_t;

	// digit code to common-cathode pattern, bit7 = decimal point
	function automatic logic [7:0] code_to_pattern(input code_t code);
		logic [7:0] g;
		logic [3:0] d;
		begin
			if (code < 5'd10) begin
				d = code[3:0];
			end else begin
				d = 4'(code - DP_OFFSET);
			end
			case (d)
				4'd0: g = 8'h3f;
				4'd1: g = 8'h06;
				4'd2: g = 8'h5b;
				4'd3: g = 8'h4f;
				4'd4: g = 8'h66;
				4'd5: g = 8'h6d;
				4'd6: g = 8'h7d;
				4'd7: g = 8'h07;
				4'd8: g = 8'h7f;
				4'd9: g = 8'h6f;
				default: g = 8'h00;
			endcase
			if (code >= 5'd20) begin
				code_to_pattern = 8'h00;
			end else if (code >= 5'd10) begin
				code_to_pattern = g | 8'h80;
			end else begin
				code_to_pattern = g;
			end
		end
	endfunction

endpackage

// ===== rtl/core/meter_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// meter_seven_segment_scan
// Three-digit multiplexed seven-segment driver for a meter reading in hundredths.
// ----------------------------------------------------------------------------
// A refresh result passes the input, stage 2 and output registers. Throughput: one
// request per cycle unless stalled; loads and ticks may follow back to back.
// The digit split is two register stages of constant-reciprocal multiplies.
// Reset (arst_n low): stage valids, digit codes and scan index clear to zero.
// Loads produce no output request; every tick produces exactly one.
module meter_seven_segment_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	// input request
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [13:0] reading, rest zero
	input  logic                                s_axis_tuser,  // [0] action
	// output request
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [mss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [7:0] segments,
	                                                           // [10:8] commons,
	                                                           // [12:11] digit_shown
);

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic             vld_s1;
	mss_pkg::action_t act_s1;
	logic [13:0]      rd_s1;

	// Stage 2: saturated/rounded value in tens plus units digit
	logic             vld_s2;
	mss_pkg::action_t act_s2;
	logic [9:0]       q_s2;      // reading/10, plus one when rounded up
	logic [3:0]       units_s2;  // reading%10 (used below the split limit)
	logic             big_s2;    // reading >= 1000 -> xx.x

	// Display state
	mss_pkg::code_t   codes_q [mss_pkg::NUM_DIGITS];
	logic [1:0]       scan_q;

	// Output register
	logic             out_vld_q;
	logic [7:0]       seg_q;
	logic [2:0]       com_q;
	logic [1:0]       dig_q;

	// Backpressure: a load in stage 2 never needs the output slot.
	logic rdy_s2, rdy_s1;
	assign rdy_s2        = !out_vld_q || m_axis_tready || (act_s2 == mss_pkg::ACT_LOAD);
	assign rdy_s1        = !vld_s2 || rdy_s2;
	assign s_axis_tready = !vld_s1 || rdy_s1;

	logic in_acc, adv_s1, adv_s2;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign adv_s1 = vld_s1 && rdy_s1;
	assign adv_s2 = vld_s2 && rdy_s2;

	// ------------------------------------------------------------------
	// Stage 1 logic: saturate, divide by ten, round
	// ------------------------------------------------------------------
	logic [13:0] sat_v;
	logic [26:0] prod10;
	logic [9:0]  q10;
	logic [13:0] units_w;
	logic [3:0]  units;
	logic        big;
	logic [9:0]  q_adj;

	always_comb begin
		sat_v   = (rd_s1 > mss_pkg::MAX_READING) ? mss_pkg::MAX_READING : rd_s1;
		prod10  = 27'(sat_v) * 27'(mss_pkg::RECIP10_V);
		q10     = prod10[25:16];
		units_w = sat_v - 14'(q10) * 14'd10;
		units   = units_w[3:0];
		big     = (sat_v >= mss_pkg::SPLIT_LIMIT);
		// round up on the units digit, only for the xx.x form
		q_adj   = (big && units > 4'd5) ? 10'(q10 + 10'd1) : q10;
	end

	// ------------------------------------------------------------------
	// Stage 2 logic: split tens value into digits, build codes
	// ------------------------------------------------------------------
	logic [17:0] prod_t;
	logic [15:0] prod_h;
	logic [6:0]  t_w;    // q/10
	logic [3:0]  h_w;    // q/100, at most 10
	logic [9:0]  lo_w;
	logic [6:0]  mid_w;
	logic [3:0]  lo_d, mid_d, hi_d;
	mss_pkg::code_t new_codes [mss_pkg::NUM_DIGITS];

	always_comb begin
		prod_t = 18'(q_s2) * 18'(mss_pkg::RECIP10_Q);
		prod_h = 16'(q_s2) * 16'(mss_pkg::RECIP100_Q);
		t_w    = prod_t[17:11];
		h_w    = prod_h[15:12];
		lo_w   = q_s2 - 10'(t_w) * 10'd10;
		mid_w  = t_w - 7'(h_w) * 7'd10;
		lo_d   = lo_w[3:0];
		mid_d  = mid_w[3:0];
		hi_d   = (h_w == 4'd10) ? 4'd0 : h_w;  // thousands wraps after rounding overflow
		if (big_s2) begin
			new_codes[0] = {1'b0, hi_d};
			new_codes[1] = 5'(mid_d) + mss_pkg::DP_OFFSET;
			new_codes[2] = {1'b0, lo_d};
		end else begin
			new_codes[0] = 5'(t_w[3:0]) + mss_pkg::DP_OFFSET;
			new_codes[1] = {1'b0, lo_d};
			new_codes[2] = {1'b0, units_s2};
		end
	end

	// Tick: drive current scan digit
	logic [1:0]     idx;
	logic [1:0]     idx_nxt;
	mss_pkg::code_t cur_code;
	logic [2:0]     com_w;

	always_comb begin
		idx      = (scan_q == 2'd3) ? 2'd0 : scan_q;
		idx_nxt  = (idx == 2'(mss_pkg::NUM_DIGITS - 1)) ? 2'd0 : 2'(idx + 2'd1);
		cur_code = codes_q[idx];
		com_w    = 3'b111 & ~(3'b001 << idx);
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			scan_q    <= 2'd0;
			for (int i = 0; i < mss_pkg::NUM_DIGITS; i++) begin
				codes_q[i] <= '0;
			end
		end else begin
			if (s_axis_tready) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (rdy_s1) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s2 && act_s2 == mss_pkg::ACT_TICK) begin
				out_vld_q <= 1'b1;
				scan_q    <= idx_nxt;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (adv_s2 && act_s2 == mss_pkg::ACT_LOAD) begin
				for (int i = 0; i < mss_pkg::NUM_DIGITS; i++) begin
					codes_q[i] <= new_codes[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1 <= mss_pkg::action_t'(s_axis_tuser);
			rd_s1  <= s_axis_tdata[13:0];
		end
		if (adv_s1) begin
			act_s2   <= act_s1;
			q_s2     <= q_adj;
			units_s2 <= units;
			big_s2   <= big;
		end
		if (adv_s2 && act_s2 == mss_pkg::ACT_TICK) begin
			seg_q <= mss_pkg::code_to_pattern(cur_code);
			com_q <= com_w;
			dig_q <= idx;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, dig_q, com_q, seg_q};

endmodule

// ===== rtl/core/mss_checker.sv =====
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for the display scan driver, bound to the top level.
// ----------------------------------------------------------------------------
module mss_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mss_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [2:0] com;
	logic [1:0] dig;
	logic       out_acc;
	logic [1:0] last_q;
	logic       have_q;
	logic [1:0] exp_dig;

	assign com     = m_axis_tdata[10:8];
	assign dig     = m_axis_tdata[12:11];
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign exp_dig = (last_q == 2'd2) ? 2'd0 : 2'(last_q + 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			last_q <= 2'd0;
		end else if (out_acc) begin
			have_q <= 1'b1;
			last_q <= dig;
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output request changed while stalled");

	// exactly one common low, matching the shown digit
	a_common: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (dig == 2'd0 && com == 3'b110) || (dig == 2'd1 && com == 3'b101)
		                || (dig == 2'd2 && com == 3'b011))
		else $error("commons do not match digit_shown");

	// scan steps 0,1,2,0 across delivered results
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && have_q |-> dig == exp_dig)
		else $error("scan order broken");

	// first result after reset shows the leftmost digit
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !have_q |-> dig == 2'd0)
		else $error("first scan digit not leftmost");

	// unused upper bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:13] == 3'b000)
		else $error("padding bits set");

endmodule

bind meter_seven_segment_scan mss_checker u_mss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== bench/meter_seven_segment_scan_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// meter_seven_segment_scan_tb
// Self-checking bench for the three-digit meter display scan driver.
// Loads and refresh ticks go in over the input stream. A local model of the
// digit split and the scan order predicts every tick's output request.
// Output requests are checked field by field, in order, under random idling.
// ----------------------------------------------------------------------------
module meter_seven_segment_scan_tb;

	localparam int SETTLE_CYCLES = 12;  // settle margin after the refresh pipeline drains

	// seven-segment glyphs for 0..9, bit0 = A .. bit6 = G
	localparam logic [7:0] SEG_GLYPH [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	typedef struct packed {
		logic [7:0] segments;
		logic [2:0] commons;
		logic [1:0] digit_shown;
	} scan_out_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [mss_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [13:0] reading, [15:14] zero
	logic                            s_axis_tuser  = 1'b0; // [0] action
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [mss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // [7:0] segments, [10:8] commons,
	                                                // [12:11] digit_shown

	// bench copy of the display state
	logic [4:0] shadow_codes [mss_pkg::NUM_DIGITS] = '{default: 5'd0};
	logic [1:0] shadow_scan = 2'd0;
	scan_out_t  pending_scans [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int failures       = 0;
	int scans_checked  = 0;
	int loads_sent     = 0;
	int ticks_sent     = 0;
	int sat_loads      = 0;
	int rounded_loads  = 0;

	meter_seven_segment_scan i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Display model
	// ---------------------------------------------------------------------

	// code 0..9 plain digit, 10..19 digit with decimal point, else blank
	function automatic logic [7:0] pattern_for(logic [4:0] code);
		if (code < 5'd10)
			return SEG_GLYPH[code];
		if (code < 5'd20)
			return SEG_GLYPH[code - 5'd10] | 8'h80;
		return 8'h00;
	endfunction

	// split a load into three digit codes: x.xx below 1000, rounded xx.x from 1000 up
	function automatic void latch_reading(logic [13:0] raw);
		int v;
		v = raw;
		if (v > mss_pkg::MAX_READING) begin
			v = mss_pkg::MAX_READING;
			sat_loads++;
		end
		if (v >= mss_pkg::SPLIT_LIMIT) begin
			// units above 5 round the tenths up; 9996..9999 wrap the thousands
			if (v % 10 > 5) begin
				v += 10;
				rounded_loads++;
			end
			shadow_codes[0] = 5'((v / 1000) % 10);
			shadow_codes[1] = 5'((v / 100) % 10 + 10);
			shadow_codes[2] = 5'((v / 10) % 10);
		end else begin
			shadow_codes[0] = 5'((v / 100) % 10 + 10);
			shadow_codes[1] = 5'((v / 10) % 10);
			shadow_codes[2] = 5'(v % 10);
		end
	endfunction

	// one refresh: drive the current digit, then step the scan 0 -> 1 -> 2 -> 0
	function automatic scan_out_t scan_next();
		scan_out_t  r;
		logic [1:0] idx;
		idx = (shadow_scan >= 2'(mss_pkg::NUM_DIGITS)) ? 2'd0 : shadow_scan;
		r.segments    = pattern_for(shadow_codes[idx]);
		r.commons     = 3'b111 & ~(3'b001 << idx);
		r.digit_shown = idx;
		shadow_scan   = (idx == 2'(mss_pkg::NUM_DIGITS - 1)) ? 2'd0 : idx + 2'd1;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Sender: one request, random idle cycles first; valid stays up between
	// back-to-back requests. Prediction happens at acceptance.
	// ---------------------------------------------------------------------
	task automatic send_request(mss_pkg::action_t act, logic [13:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {2'b00, value};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (act == mss_pkg::ACT_LOAD) begin
			latch_reading(value);
			loads_sent++;
		end else begin
			pending_scans.push_back(scan_next());
			ticks_sent++;
		end
	endtask

	task automatic tick_times(int n);
		repeat (n) send_request(mss_pkg::ACT_TICK, 14'($urandom_range(16383)));
	endtask

	// weighted toward the split limit, the rounding edge and saturation
	function automatic logic [13:0] pick_reading();
		case ($urandom_range(5))
			0:       return 14'($urandom_range(16383));
			1:       return 14'($urandom_range(999));
			2, 3:    return 14'($urandom_range(9999, 1000));
			4:       return 14'($urandom_range(1009, 990));
			default: return 14'($urandom_range(10010, 9990));
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stalls; every accepted output request is compared
	// against the oldest prediction.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_scans
		scan_out_t got;
		scan_out_t want;
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.segments    = m_axis_tdata[7:0];
			got.commons     = m_axis_tdata[10:8];
			got.digit_shown = m_axis_tdata[12:11];
			if (pending_scans.size() == 0) begin
				if (failures < 10)
					$display("%0t: output request with none expected: seg %h com %b dig %0d",
						$time, got.segments, got.commons, got.digit_shown);
				failures++;
			end else begin
				want = pending_scans.pop_front();
				scans_checked++;
				if (got.segments !== want.segments || got.commons !== want.commons ||
						got.digit_shown !== want.digit_shown) begin
					if (failures < 10)
						$display("%0t: scan mismatch: exp seg %h com %b dig %0d, got seg %h com %b dig %0d",
							$time, want.segments, want.commons, want.digit_shown,
							got.segments, got.commons, got.digit_shown);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// codes clear to zero on reset: three plain zeros, scan starts at digit 0
	task automatic test_after_reset();
		tick_times(3);
	endtask

	task automatic test_split_cases();
		send_request(mss_pkg::ACT_LOAD, 14'd16383);  // saturates, then rounding wraps: 0 0. 0
		tick_times(3);
		send_request(mss_pkg::ACT_LOAD, 14'd1006);   // rounds 10.06 up to 10.1, shown as 1 0. 1
		tick_times(3);
		send_request(mss_pkg::ACT_LOAD, 14'd999);    // top of x.xx range
		tick_times(3);
		send_request(mss_pkg::ACT_LOAD, 14'd0);      // back-to-back loads, last one wins
		send_request(mss_pkg::ACT_LOAD, 14'd1005);   // no rounding at exactly 5
		tick_times(4);                               // fourth tick checks the scan wrap
		send_request(mss_pkg::ACT_LOAD, 14'd8196);
		tick_times(2);
	endtask

	task automatic test_random_mix(int idle_pct, int stall_pct, int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			if ($urandom_range(99) < 35)
				send_request(mss_pkg::ACT_LOAD, pick_reading());
			else
				send_request(mss_pkg::ACT_TICK, 14'($urandom_range(16383)));
		end
	endtask

	// sender holds off until every predicted scan has come out
	task automatic test_drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_split_cases();
		test_random_mix(0, 0, 300);
		test_drain_pause();
		test_random_mix(87, 0, 300);
		test_random_mix(0, 87, 300);
		test_drain_pause();
		test_random_mix(38, 38, 300);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		failures += pending_scans.size();

		$display("Sent %0d loads (%0d saturated, %0d rounded up) and %0d refresh ticks;",
			loads_sent, sat_loads, rounded_loads, ticks_sent);
		$display("checked %0d scan outputs under mixed sender idling and receiver stalls.",
			scans_checked);
		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5000000;
		$display("Timeout with %0d scans still outstanding", pending_scans.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
